[rtl/core/ddim_pkg.sv]
// Package with constants, types and arithmetic helpers for the DDIM denoise step unit.
`timescale 1ns / 1ps
`default_nettype none

package ddim_pkg;

    // Schedule defaults and fixed-point constants (coefficients are unsigned Q6.26).
    localparam int unsigned TRAIN_STEPS_DEF = 1000;
    localparam int unsigned BETA_FIRST      = 57043;
    localparam int unsigned BETA_SPAN       = 748263;
    localparam int unsigned Q_ONE           = 32'd67108864;
    localparam logic [9:0]  TIMESTEP_RESET  = 10'd999;
    localparam logic [30:0] INV_SAT         = 31'h7FFF_FFFF;

    // Number of steps of the iterative square root and divider.
    localparam int unsigned SQRT_STEPS = 27;
    localparam int unsigned DIV_STEPS  = 53;

    // State of one bit-serial square root unit.
    typedef struct packed {
        logic [53:0] rad;
        logic [28:0] rem;
        logic [26:0] root;
    } sqrt_t;

    // One result bit of the square root per call.
    function automatic sqrt_t sqrt_step(input sqrt_t s);
        sqrt_t       r;
        logic [28:0] rem_sh;
        logic [28:0] trial;
        begin
            rem_sh = {s.rem[26:0], s.rad[53:52]};
            trial  = {s.root, 2'b01};
            r.rad  = {s.rad[51:0], 2'b00};
            if (rem_sh >= trial)
            begin
                r.rem  = rem_sh - trial;
                r.root = {s.root[25:0], 1'b1};
            end
            else
            begin
                r.rem  = rem_sh;
                r.root = {s.root[25:0], 1'b0};
            end
            return r;
        end
    endfunction

    // Divide by 2^s, rounding half away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int unsigned s);
        logic signed [63:0] half;
        logic signed [63:0] mag;
        logic signed [63:0] q;
        begin
            half = 64'sd1 <<< (s - 1);
            mag  = (v < 0) ? -v : v;
            q    = (mag + half) >>> s;
            return (v < 0) ? -q : q;
        end
    endfunction

    // Saturate to the Q3.12 range; the top bit flags saturation.
    function automatic logic [16:0] sat16(input logic signed [63:0] v);
        begin
            if (v > 64'sd32767)
                return {1'b1, 16'h7FFF};
            else if (v < -64'sd32768)
                return {1'b1, 16'h8000};
            else
                return {1'b0, v[15:0]};
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/ddim_denoise_step_unit.sv]
// Top level of the DDIM denoise step unit: schedule builder, coefficient tables and datapath.
`timescale 1ns / 1ps
`default_nettype none
//
// The unit applies one deterministic DDIM update (eta = 0) to a stream of latent elements.
// Input words on s_* carry a Q3.12 sample and its predicted noise; output words on m_*
// carry the Q3.12 element for the previous timestep and a saturation flag in m_tuser.
// The cfg_* channel writes the timestep; a timestep past the table end uses the last entry.
// After reset a sequencer fills the root, inverse-root and complement-root tables one entry
// at a time; for each entry a 27-step square root pair and a 53-step divider run one after
// the other and share no time. During that time s_tready and cfg_ready are low. Each
// timestep write then reads the tables into coefficient registers in the states ST_FETCH0,
// ST_FETCH1 and ST_FETCH2, with s_tready low.
// The datapath is a six-stage pipeline that takes one word per cycle while it is not held.
// When the receiver holds m_tready low while an output word waits, the whole pipeline holds
// and s_tready drops in the same cycle; nothing is lost or repeated.
// Timestep writes are expected only while the pipeline is empty.
//
module ddim_denoise_step_unit
    import ddim_pkg::*;
#(
    parameter int unsigned TRAIN_STEPS = TRAIN_STEPS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] sample_value, [31:16] noise_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] previous_value
    output logic [0:0]       m_tuser,   // [0] clipped
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data
);

    localparam int unsigned IDX_W  = $clog2(TRAIN_STEPS);
    localparam int unsigned LAST   = TRAIN_STEPS - 1;
    localparam int unsigned DENOM  = TRAIN_STEPS - 1;
    localparam int unsigned Q_INC  = BETA_SPAN / DENOM;
    localparam int unsigned R_INC  = BETA_SPAN % DENOM;

    typedef enum logic [8:0] {
        ST_BETA   = 9'b000000001,
        ST_CUM    = 9'b000000010,
        ST_SQRT   = 9'b000000100,
        ST_DIV    = 9'b000001000,
        ST_WRITE  = 9'b000010000,
        ST_FETCH0 = 9'b000100000,
        ST_FETCH1 = 9'b001000000,
        ST_FETCH2 = 9'b010000000,
        ST_RUN    = 9'b100000000
    } state_t;

    // Sequencer registers.
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [19:0]         acc_q_reg, acc_q_next;
    logic [12:0]         acc_r_reg, acc_r_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [9:0]          timestep_reg, timestep_next;
    logic [26:0]         alpha_reg, alpha_next;
    logic [53:0]         cprod_reg, cprod_next;
    logic [26:0]         cum_reg, cum_next;
    sqrt_t               sa_reg, sa_next, sc_reg, sc_next;
    logic [52:0]         div_num_reg, div_num_next;
    logic [27:0]         div_rem_reg, div_rem_next;
    logic [26:0]         comp_t_reg, comp_t_next;
    logic [30:0]         inv_t_reg, inv_t_next;
    logic [26:0]         rp_reg, rp_next;
    logic [26:0]         cp_reg, cp_next;

    // Coefficient tables and their registered read data.
    logic [31:0]         root_mem [TRAIN_STEPS];
    logic [31:0]         comp_mem [TRAIN_STEPS];
    logic [31:0]         inv_mem  [TRAIN_STEPS];
    logic [31:0]         root_rd, comp_rd, inv_rd;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [31:0]         inv_wr;

    logic [IDX_W-1:0]    t_clamp;
    logic [26:0]         cum_new;
    logic [26:0]         comp_arg;
    logic [27:0]         div_sh;
    logic [12:0]         acc_r_sum;
    sqrt_t               sa_step, sc_step;

    // Clamp the timestep to the table.
    always_comb
    begin
        if (13'(timestep_reg) >= 13'(TRAIN_STEPS))
            t_clamp = IDX_W'(LAST);
        else
            t_clamp = IDX_W'(timestep_reg);
    end

    // Helpers for the schedule recurrence and the serial units.
    always_comb
    begin
        if (idx_reg == '0)
            cum_new = alpha_reg;
        else
            cum_new = 27'((cprod_reg + 54'(Q_ONE / 2)) >> 26);
        comp_arg  = 27'(Q_ONE) - cum_new;
        sa_step   = sqrt_step(sa_reg);
        sc_step   = sqrt_step(sc_reg);
        div_sh    = {div_rem_reg[26:0], div_num_reg[52]};
        acc_r_sum = acc_r_reg + 13'(R_INC);
        if (sa_reg.root == '0 || div_num_reg[52:31] != '0)
            inv_wr = {1'b0, INV_SAT};
        else
            inv_wr = {1'b0, div_num_reg[30:0]};
    end

    // Memory read address: current timestep first, then the one before it.
    always_comb
    begin
        if (state_reg == ST_FETCH1)
            rd_addr = (t_clamp == '0) ? '0 : t_clamp - IDX_W'(1);
        else
            rd_addr = t_clamp;
    end

    assign wr_en     = (state_reg == ST_WRITE);
    assign cfg_ready = (state_reg == ST_RUN);

    // Schedule sequencer, coefficient fetch and timestep register.
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        acc_q_next    = acc_q_reg;
        acc_r_next    = acc_r_reg;
        cnt_next      = cnt_reg;
        timestep_next = timestep_reg;
        alpha_next    = alpha_reg;
        cprod_next    = cprod_reg;
        cum_next      = cum_reg;
        sa_next       = sa_reg;
        sc_next       = sc_reg;
        div_num_next  = div_num_reg;
        div_rem_next  = div_rem_reg;
        comp_t_next   = comp_t_reg;
        inv_t_next    = inv_t_reg;
        rp_next       = rp_reg;
        cp_next       = cp_reg;
        unique case (state_reg)
            ST_BETA:
            begin
                alpha_next = 27'(Q_ONE) - 27'(BETA_FIRST) - 27'(acc_q_reg);
                cprod_next = 54'(cum_reg) * 54'(alpha_next);
                state_next = ST_CUM;
            end
            ST_CUM:
            begin
                cum_next   = cum_new;
                sa_next    = '{rad: {1'b0, cum_new, 26'b0}, rem: '0, root: '0};
                sc_next    = '{rad: {1'b0, comp_arg, 26'b0}, rem: '0, root: '0};
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                sa_next  = sa_step;
                sc_next  = sc_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                begin
                    div_num_next = {1'b1, 26'b0, sa_step.root[26:1]};
                    div_rem_next = '0;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_sh >= {1'b0, sa_reg.root})
                begin
                    div_rem_next = div_sh - {1'b0, sa_reg.root};
                    div_num_next = {div_num_reg[51:0], 1'b1};
                end
                else
                begin
                    div_rem_next = div_sh;
                    div_num_next = {div_num_reg[51:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // Advance floor(BETA_SPAN * i / DENOM) without a divider.
                idx_next = idx_reg + IDX_W'(1);
                if (acc_r_sum >= 13'(DENOM))
                begin
                    acc_r_next = acc_r_sum - 13'(DENOM);
                    acc_q_next = acc_q_reg + 20'(Q_INC) + 20'd1;
                end
                else
                begin
                    acc_r_next = acc_r_sum;
                    acc_q_next = acc_q_reg + 20'(Q_INC);
                end
                if (idx_reg == IDX_W'(LAST))
                    state_next = ST_FETCH0;
                else
                    state_next = ST_BETA;
            end
            ST_FETCH0:
            begin
                state_next = ST_FETCH1;
            end
            ST_FETCH1:
            begin
                comp_t_next = comp_rd[26:0];
                inv_t_next  = inv_rd[30:0];
                state_next  = ST_FETCH2;
            end
            ST_FETCH2:
            begin
                if (t_clamp == '0)
                begin
                    rp_next = 27'(Q_ONE);
                    cp_next = '0;
                end
                else
                begin
                    rp_next = root_rd[26:0];
                    cp_next = comp_rd[26:0];
                end
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (cfg_valid)
                begin
                    timestep_next = cfg_data;
                    state_next    = ST_FETCH0;
                end
            end
            default:
            begin
                state_next = ST_BETA;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_BETA;
            idx_reg      <= '0;
            acc_q_reg    <= '0;
            acc_r_reg    <= '0;
            cnt_reg      <= '0;
            timestep_reg <= TIMESTEP_RESET;
            cum_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            acc_q_reg    <= acc_q_next;
            acc_r_reg    <= acc_r_next;
            cnt_reg      <= cnt_next;
            timestep_reg <= timestep_next;
            cum_reg      <= cum_next;
        end
    end

    // Sequencer payload and coefficient registers.
    always_ff @(posedge clk)
    begin
        alpha_reg   <= alpha_next;
        cprod_reg   <= cprod_next;
        sa_reg      <= sa_next;
        sc_reg      <= sc_next;
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        comp_t_reg  <= comp_t_next;
        inv_t_reg   <= inv_t_next;
        rp_reg      <= rp_next;
        cp_reg      <= cp_next;
    end

    // Coefficient tables: one write port, one registered read port each.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            root_mem[idx_reg] <= {5'b0, sa_reg.root};
            comp_mem[idx_reg] <= {5'b0, sc_reg.root};
            inv_mem[idx_reg]  <= inv_wr;
        end
        root_rd <= root_mem[rd_addr];
        comp_rd <= comp_mem[rd_addr];
        inv_rd  <= inv_mem[rd_addr];
    end

    // Datapath pipeline.
    logic                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [43:0]  num_reg;
    logic signed [25:0]  n20_reg;
    logic signed [57:0]  prod_reg;
    logic signed [15:0]  x0_reg;
    logic signed [43:0]  m1_reg, m2_reg;
    logic signed [15:0]  eps1_reg, eps2_reg, eps3_reg, eps4_reg;
    logic                hit4_reg, hit5_reg;
    logic [15:0]         prev_reg;
    logic                clip_reg;
    logic                advance;
    logic signed [15:0]  x_in, eps_in;
    logic signed [43:0]  num_next;
    logic [16:0]         x0_sat, prev_sat;
    logic signed [44:0]  sum6;

    assign advance  = !v6_reg || m_tready;
    assign s_tready = advance && (state_reg == ST_RUN);
    assign x_in     = s_tdata[15:0];
    assign eps_in   = s_tdata[31:16];

    // Stage arithmetic.
    always_comb
    begin
        num_next = (44'(x_in) <<< 26)
                 - 44'(signed'({1'b0, comp_t_reg})) * 44'(eps_in);
        x0_sat   = sat16(round_shift(64'(prod_reg), 34));
        sum6     = 45'(m1_reg) + 45'(m2_reg);
        prev_sat = sat16(round_shift(64'(sum6), 26));
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= s_tvalid && s_tready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_reg  <= num_next;
            eps1_reg <= eps_in;
            n20_reg  <= 26'(round_shift(64'(num_reg), 18));
            eps2_reg <= eps1_reg;
            prod_reg <= 58'(n20_reg) * 58'(signed'({1'b0, inv_t_reg}));
            eps3_reg <= eps2_reg;
            x0_reg   <= x0_sat[15:0];
            hit4_reg <= x0_sat[16];
            eps4_reg <= eps3_reg;
            m1_reg   <= 44'(signed'({1'b0, rp_reg})) * 44'(x0_reg);
            m2_reg   <= 44'(signed'({1'b0, cp_reg})) * 44'(eps4_reg);
            hit5_reg <= hit4_reg;
            prev_reg <= prev_sat[15:0];
            clip_reg <= hit5_reg || prev_sat[16];
        end
    end

    assign m_tvalid = v6_reg;
    assign m_tdata  = prev_reg;
    assign m_tuser  = clip_reg;

endmodule

`default_nettype wire

[tb/tb_ddim_denoise_step_unit.sv]
// Self-checking testbench for the DDIM denoise step unit.
`timescale 1ns / 1ps

module tb_ddim_denoise_step_unit;
    import ddim_pkg::*;

    localparam int unsigned STEPS       = 1000;
    localparam longint      CYCLE_LIMIT = 600000;
    localparam int          DRAIN_WAIT  = 16;

    // One expected output word.
    typedef struct {
        logic [15:0] value;
        logic        clipped;
    } prev_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [15:0] sample_value, [31:16] noise_value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [15:0] previous_value
    logic [0:0]  m_tuser;        // [0] clipped
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [9:0]  cfg_data = '0;

    // Mirror of the schedule tables and the timestep register.
    longint unsigned root_tab [STEPS];
    longint unsigned inv_tab  [STEPS];
    longint unsigned comp_tab [STEPS];
    logic [9:0]      step_reg = TIMESTEP_RESET;

    prev_word_t pending_prev[$];
    int         error_count = 0;
    bit         idle_enable = 1'b1;
    longint     cycle_count = 0;

    ddim_denoise_step_unit #(.TRAIN_STEPS(STEPS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint div_round(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    // Build the coefficient tables from the linear beta schedule.
    task automatic build_tables();
        longint unsigned cum;
        longint unsigned alpha;
        longint unsigned root;
        longint unsigned inv;
        cum = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            alpha = 64'd67108864 - (64'd57043 + (64'd748263 * i) / (STEPS - 1));
            if (i == 0)
                cum = alpha;
            else
                cum = (cum * alpha + 64'd33554432) >> 26;
            root = isqrt(cum << 26);
            comp_tab[i] = isqrt((64'd67108864 - cum) << 26);
            if (root == 0)
                inv = 64'h7FFF_FFFF;
            else
            begin
                inv = ((64'd1 << 52) + (root >> 1)) / root;
                if (inv > 64'h7FFF_FFFF)
                    inv = 64'h7FFF_FFFF;
            end
            root_tab[i] = root;
            inv_tab[i]  = inv;
        end
    endtask

    // Clamp to Q3.12 and note whether the clamp was hit.
    function automatic longint clamp_q12(input longint v, inout logic hit);
        if (v > 32767)
        begin
            hit = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            hit = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    // Expected denoised element for one sample and noise pair.
    function automatic prev_word_t denoise(input logic signed [15:0] x,
                                           input logic signed [15:0] eps);
        prev_word_t w;
        int         t;
        longint     rp;
        longint     cp;
        longint     n20;
        longint     x0;
        longint     p;
        logic       hit;
        hit = 1'b0;
        t = (step_reg >= STEPS) ? STEPS - 1 : int'(step_reg);
        if (t == 0)
        begin
            rp = 64'd67108864;
            cp = 0;
        end
        else
        begin
            rp = longint'(root_tab[t - 1]);
            cp = longint'(comp_tab[t - 1]);
        end
        n20 = div_round(longint'(x) * 67108864 - longint'(comp_tab[t]) * longint'(eps), 18);
        x0 = clamp_q12(div_round(n20 * longint'(inv_tab[t]), 34), hit);
        p = clamp_q12(div_round(rp * x0 + cp * longint'(eps), 26), hit);
        w.value = p[15:0];
        w.clipped = hit;
        return w;
    endfunction

    // Send one word; the valid stays high when the next word follows at once.
    task automatic send_pair(input logic [15:0] x, input logic [15:0] eps);
        int gap;
        gap = idle_enable ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {eps, x};
        do
            @(posedge clk);
        while (!s_tready);
        pending_prev.insert(pending_prev.size(), denoise(x, eps));
    endtask

    // Stop sending and wait until every expected word has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_prev.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_timestep(input logic [9:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        step_reg = value;
    endtask

    function automatic logic [15:0] corner_value(input int k);
        case (k % 5)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'h1000;
        endcase
    endfunction

    // Extreme sample and noise combinations at the current timestep.
    task automatic test_corners();
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j += 2)
                send_pair(corner_value(i), corner_value(j));
    endtask

    // Reset timestep, steps 0 and 1, and a step past the table end.
    task automatic test_timestep_edges();
        test_corners();
        write_timestep(10'd0);
        test_corners();
        write_timestep(10'd1);
        test_corners();
        write_timestep(10'd1023);
        test_corners();
    endtask

    // Random words over a range of timesteps, mostly realistic magnitudes.
    task automatic test_random_steps(input int count);
        logic [15:0] x;
        logic [15:0] eps;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                case ((i / 150) % 4)
                    0: write_timestep(10'($urandom_range(0, 1023)));
                    1: write_timestep(10'd999);
                    2: write_timestep(10'($urandom_range(0, 20)));
                    default: write_timestep(10'($urandom_range(0, 999)));
                endcase
            end
            if ($urandom_range(0, 3) == 0)
            begin
                x   = 16'($urandom);
                eps = 16'($urandom);
            end
            else
            begin
                x   = 16'($signed($urandom_range(0, 16383)) - 8192);
                eps = 16'($signed($urandom_range(0, 16383)) - 8192);
            end
            send_pair(x, eps);
        end
    endtask

    // A stretch with neither side idling.
    task automatic test_full_rate(input int count);
        idle_enable = 1'b0;
        write_timestep(10'd500);
        for (int i = 0; i < count; i++)
            send_pair(16'($urandom), 16'($urandom));
        drain();
        idle_enable = 1'b1;
    endtask

    // Receiver: check each accepted word, then draw the next stall.
    initial
    begin
        int         stall;
        prev_word_t want;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_prev.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual value %h clipped %b",
                             $time, m_tdata, m_tuser[0]);
                    error_count++;
                end
                else
                begin
                    want = pending_prev.pop_front();
                    if (m_tdata !== want.value)
                    begin
                        $display("%0t: previous_value mismatch: expected %h, actual %h",
                                 $time, want.value, m_tdata);
                        error_count++;
                    end
                    if (m_tuser[0] !== want.clipped)
                    begin
                        $display("%0t: clipped mismatch: expected %b, actual %b",
                                 $time, want.clipped, m_tuser[0]);
                        error_count++;
                    end
                end
                stall = idle_enable ? $urandom_range(0, 5) : 0;
            end
            else if (stall > 0)
                stall--;
            m_tready <= (stall == 0);
        end
    end

    // Watchdog on total run length.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("** ddim_denoise_step_unit: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        build_tables();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_timestep_edges();
        test_random_steps(1200);
        test_full_rate(190);
        drain();
        if (error_count == 0)
            $display("** ddim_denoise_step_unit: PASSED **");
        else
            $display("** ddim_denoise_step_unit: FAILED **");
        $finish;
    end

endmodule
